[rtl/core/cross_track_error_polyline_macros.svh]
// Assertion macros for the cross-track error block.
// Used by the sequencer and the top level; no other dependencies.
`ifndef CROSS_TRACK_ERROR_POLYLINE_MACROS_SVH
`define CROSS_TRACK_ERROR_POLYLINE_MACROS_SVH
`ifndef SYNTHESIS
`define CTE_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define CTE_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define CTE_ASSERT_IMP(label, clk, rst, a, c)
`define CTE_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

[rtl/core/cte_pkg.sv]
// Shared constants and types for the cross-track error block.
// No dependencies.
`default_nettype none
package cte_pkg;
   localparam int MaxPoints = 256;
   localparam int FracBits  = 16;
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int CntW      = IdxW + 1;
   localparam logic [63:0] ZeroLenUnits =
      64'((((65'd1 << (2 * FracBits)) + 65'd9999999999) / 65'd10000000000));

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;
endpackage
`default_nettype wire

[rtl/core/cross_track_error_polyline.sv]
// Top level of the cross-track error block: store, sequencer and datapath.
// Depends on cte_pkg, cte_ram and the assertion macro header.
//
// Requests: append a point, clear, or query. Append and clear pass through
// the write state and S_DONE, the unused operation through S_DONE alone,
// and a new request is taken only in idle. A query walks each stored
// segment in turn through one shared 34x34 multiplier, wide adders and a
// one-bit-per-cycle divider. A segment whose two end points are valid goes
// through three states of reads and capture, six multiply steps, the clamp
// decision, then, when the projection falls inside it, 32 division steps
// and three offset multiplies, and last three squaring steps and the
// compare. A zero-length segment goes from the multiply steps straight to
// the squaring steps; a segment with an invalid end point goes from the
// capture straight to the compare. A query over fewer than two points goes
// straight to the square root, which is followed by the result state. busy
// is high for the whole request. The one result of a query appears on the
// rsp_ ports for a single cycle marked by rsp_valid; the receiver cannot
// stall it, so it must take it in that cycle.
`default_nettype none
`include "cross_track_error_polyline_macros.svh"
module cross_track_error_polyline (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic signed [31:0] req_x,
   input  wire logic signed [31:0] req_y,
   input  wire logic signed [31:0] req_z,
   input  wire logic        req_point_valid,
   output logic             rsp_valid,
   output logic [31:0]      rsp_distance,
   output logic [7:0]       rsp_segment_start,
   output logic             rsp_found,
   output logic             rsp_overflow
);
   localparam int IW = cte_pkg::IdxW;
   localparam int CW = cte_pkg::CntW;

   // Which vector the squaring steps work on.
   localparam logic [1:0] ModeProj  = 2'd0;   // offset from the projected point
   localparam logic [1:0] ModeStart = 2'd1;   // offset from the start point
   localparam logic [1:0] ModeEnd   = 2'd2;   // offset from the end point

   // States, one-hot.
   typedef enum logic [12:0] {
      S_IDLE   = 13'd1,
      S_RDS    = 13'd2,     // read start point
      S_RDE    = 13'd4,     // read end point
      S_LATE   = 13'd8,     // capture end point
      S_MUL    = 13'd16,    // multiply/accumulate microsteps
      S_DIV    = 13'd32,    // projection division
      S_OFF    = 13'd64,    // offset multiplies
      S_FIN    = 13'd128,   // squared-distance microsteps
      S_CMP    = 13'd256,   // compare and next segment
      S_SQRT   = 13'd512,
      S_OUT    = 13'd1024,
      S_WR     = 13'd2048,
      S_DONE   = 13'd4096
   } state_type;

   state_type state_ff, state_in;

   // Store: x,y,z,valid packed in one RAM word.
   logic          ram_we;
   logic [IW-1:0] ram_addr;
   logic [96:0]   ram_wd, ram_rd;
   cte_ram #(.Width(97), .Depth(cte_pkg::MaxPoints)) u_store (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd));

   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [1:0]    op_ff, op_in;
   logic signed [32:0] q_ff [3], q_in [3];
   logic          pv_ff, pv_in;
   logic [CW-1:0] seg_ff, seg_in;
   logic signed [33:0] p_ff [3], p_in [3];
   logic signed [33:0] d_ff [3], d_in [3];
   logic          sval_ff, sval_in;
   logic [3:0]    step_ff, step_in;
   logic [5:0]    bit_ff, bit_in;
   logic [129:0]  acc_ff, acc_in;     // general accumulator
   logic [129:0]  len_ff, len_in;
   logic [129:0]  pos_ff, pos_in;
   logic [129:0]  neg_ff, neg_in;
   logic [129:0]  rem_ff, rem_in;
   logic [31:0]   t_ff, t_in;
   logic signed [33:0] r_ff [3], r_in [3];
   logic [129:0]  best_ff, best_in;
   logic [IW-1:0] bidx_ff, bidx_in;
   logic          have_ff, have_in;
   logic [63:0]   sq_n_ff, sq_n_in, sq_res_ff, sq_res_in;
   logic [63:0]   sq_bit_ff, sq_bit_in;
   logic [31:0]   dist_ff, dist_in;
   logic [1:0]    mode_ff, mode_in;   // one of the Mode constants above

   // Shared multiplier: magnitudes of two 34-bit signed values.
   logic signed [33:0] ma, mb;
   logic [33:0]   mag_a, mag_b;
   logic [67:0]   mprod;
   always_comb begin
      mag_a = ma[33] ? 34'(-ma) : 34'(ma);
      mag_b = mb[33] ? 34'(-mb) : 34'(mb);
      mprod = mag_a * mag_b;
   end

   function automatic logic signed [33:0] sx(input logic [31:0] v);
      sx = 34'(signed'(v));
   endfunction

   always_comb begin
      logic [129:0] prod_w, dsub, sub;
      logic         dot_ge;
      logic [1:0]   k;
      logic [33:0]  off;
      logic [63:0]  tr;
      state_in = state_ff;
      count_in = count_ff; drop_in = drop_ff; op_in = op_ff; pv_in = pv_ff;
      q_in = q_ff; seg_in = seg_ff; p_in = p_ff; d_in = d_ff; sval_in = sval_ff;
      step_in = step_ff; bit_in = bit_ff; acc_in = acc_ff; len_in = len_ff;
      pos_in = pos_ff; neg_in = neg_ff; rem_in = rem_ff; t_in = t_ff;
      r_in = r_ff; best_in = best_ff; bidx_in = bidx_ff; have_in = have_ff;
      sq_n_in = sq_n_ff; sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff;
      dist_in = dist_ff; mode_in = mode_ff;
      ram_we = 1'b0; ram_addr = seg_ff[IW-1:0];
      ram_wd = {pv_ff, q_ff[2][31:0], q_ff[1][31:0], q_ff[0][31:0]};
      ma = '0; mb = '0;
      prod_w = 130'(mprod);
      dsub = '0; sub = '0; dot_ge = 1'b0; off = '0; tr = '0;
      k = step_ff[1:0] == 2'd3 ? 2'd0 : step_ff[1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_op; pv_in = req_point_valid;
               q_in[0] = 33'(req_x); q_in[1] = 33'(req_y); q_in[2] = 33'(req_z);
               seg_in = '0; have_in = 1'b0; best_in = '0; bidx_in = '0;
               case (cte_pkg::op_type'(req_op))
                  cte_pkg::OP_APPEND: state_in = S_WR;
                  cte_pkg::OP_CLEAR:  state_in = S_WR;
                  cte_pkg::OP_QUERY:  state_in = S_RDS;
                  default:            state_in = S_DONE;
               endcase
            end
         end
         S_WR: begin
            if (op_ff == cte_pkg::OP_CLEAR) begin
               count_in = '0; drop_in = 1'b0;
            end else if (count_ff < CW'(cte_pkg::MaxPoints)) begin
               ram_we = 1'b1; ram_addr = count_ff[IW-1:0];
               count_in = count_ff + 1'b1;
            end else begin
               drop_in = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         S_RDS: begin
            if (CW'(seg_ff + 1'b1) >= count_ff) begin
               state_in = S_SQRT;
               sq_n_in = best_ff[63:0]; sq_res_in = '0;
               sq_bit_in = 64'd1 << 62;
            end else begin
               ram_addr = seg_ff[IW-1:0];
               state_in = S_RDE;
            end
         end
         S_RDE: begin
            ram_addr = IW'(seg_ff + 1'b1);
            for (int i = 0; i < 3; i++) begin
               p_in[i] = 34'(q_ff[i]) - sx(ram_rd[32*i +: 32]);
               d_in[i] = -sx(ram_rd[32*i +: 32]);
            end
            sval_in = ram_rd[96];
            state_in = S_LATE;
         end
         S_LATE: begin
            for (int i = 0; i < 3; i++) d_in[i] = d_ff[i] + sx(ram_rd[32*i +: 32]);
            if (!(sval_ff && ram_rd[96])) begin
               state_in = S_CMP; sval_in = 1'b0;
            end else begin
               sval_in = 1'b1; state_in = S_MUL; step_in = '0;
               len_in = '0; pos_in = '0; neg_in = '0;
            end
         end
         S_MUL: begin
            // steps 0-2: len += d*d; 4-6: dot parts p*d
            if (step_ff < 4'd3) begin
               ma = d_ff[k]; mb = d_ff[k];
               len_in = len_ff + prod_w;
               step_in = step_ff + 1'b1;
               if (step_ff == 4'd2) step_in = 4'd4;
            end else begin
               k = 2'(step_ff - 4'd4);
               ma = p_ff[k]; mb = d_ff[k];
               if (p_ff[k][33] != d_ff[k][33]) neg_in = neg_ff + prod_w;
               else pos_in = pos_ff + prod_w;
               step_in = step_ff + 1'b1;
               if (step_ff == 4'd6) begin
                  step_in = '0; acc_in = '0;
                  if (len_ff < 130'(cte_pkg::ZeroLenUnits)) begin
                     mode_in = ModeStart; state_in = S_FIN;
                  end else state_in = S_DIV;
                  bit_in = '0;
               end
            end
         end
         S_DIV: begin
            // first cycle decides the clamp, later cycles divide
            if (bit_ff == 6'd0) begin
               dot_ge = !(neg_ff < pos_ff);
               dsub = pos_ff - neg_ff;
               if (dot_ge) begin
                  mode_in = ModeStart; state_in = S_FIN;
               end else if (!(dsub < len_ff)) begin
                  mode_in = ModeEnd; state_in = S_FIN;
               end else begin
                  rem_in = dsub; t_in = '0; bit_in = 6'd1;
               end
            end else begin
               sub = {rem_ff[128:0], 1'b0};
               if (!(sub < len_ff)) begin
                  rem_in = sub - len_ff; t_in = {t_ff[30:0], 1'b1};
               end else begin
                  rem_in = sub; t_in = {t_ff[30:0], 1'b0};
               end
               bit_in = bit_ff + 1'b1;
               if (bit_ff == 6'd32) begin
                  state_in = S_OFF; step_in = '0;
               end
            end
         end
         S_OFF: begin
            ma = 34'({2'b00, t_ff}); mb = d_ff[k];
            tr = mprod[63:0];
            off = 34'(tr[63:32]);
            r_in[k] = p_ff[k] - (d_ff[k][33] ? -off : off);
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd2) begin
               step_in = '0; mode_in = ModeProj; state_in = S_FIN;
            end
         end
         S_FIN: begin
            case (mode_ff)
               ModeStart: begin ma = p_ff[k]; mb = p_ff[k]; end
               ModeEnd: begin ma = p_ff[k] - d_ff[k]; mb = p_ff[k] - d_ff[k]; end
               default: begin ma = r_ff[k]; mb = r_ff[k]; end
            endcase
            acc_in = acc_ff + prod_w;
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd2) state_in = S_CMP;
         end
         S_CMP: begin
            if (sval_ff && (!have_ff || acc_ff < best_ff)) begin
               have_in = 1'b1; best_in = acc_ff; bidx_in = seg_ff[IW-1:0];
            end
            seg_in = seg_ff + 1'b1;
            state_in = S_RDS;
         end
         S_SQRT: begin
            if (sq_bit_ff == '0) begin
               if (!have_ff) dist_in = '0;
               else if (best_ff[129:64] != '0 || sq_res_ff[63:32] != '0) dist_in = '1;
               else dist_in = sq_res_ff[31:0];
               state_in = S_OUT;
            end else begin
               if (sq_n_ff >= sq_res_ff + sq_bit_ff) begin
                  sq_n_in = sq_n_ff - (sq_res_ff + sq_bit_ff);
                  sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
               end else sq_res_in = sq_res_ff >> 1;
               sq_bit_in = sq_bit_ff >> 2;
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; drop_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; drop_ff <= drop_in;
      end
      op_ff <= op_in; pv_ff <= pv_in; q_ff <= q_in; seg_ff <= seg_in;
      p_ff <= p_in; d_ff <= d_in; sval_ff <= sval_in; step_ff <= step_in;
      bit_ff <= bit_in; acc_ff <= acc_in; len_ff <= len_in; pos_ff <= pos_in;
      neg_ff <= neg_in; rem_ff <= rem_in; t_ff <= t_in; r_ff <= r_in;
      best_ff <= best_in; bidx_ff <= bidx_in; have_ff <= have_in;
      sq_n_ff <= sq_n_in; sq_res_ff <= sq_res_in; sq_bit_ff <= sq_bit_in;
      dist_ff <= dist_in; mode_ff <= mode_in;
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = state_ff == S_OUT;
   assign rsp_distance      = dist_ff;
   assign rsp_segment_start = 8'(bidx_ff);
   assign rsp_found         = have_ff;
   assign rsp_overflow      = drop_ff;

   `CTE_ASSERT_IMP(a_onehot, clock, reset, 1'b1, $onehot(state_ff))
   `CTE_ASSERT_IMP(a_cnt, clock, reset, 1'b1, count_ff <= CW'(cte_pkg::MaxPoints))
   `CTE_ASSERT_NXT(a_rsp, clock, reset, rsp_valid, !rsp_valid && !busy)
   `CTE_ASSERT_IMP(a_nf, clock, reset, rsp_valid && !rsp_found, rsp_distance == '0)
endmodule
`default_nettype wire

[rtl/core/cte_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module cte_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
